### hw/rtl/spx_pkg.sv
// ----------------------------------------------------------------------------
// spx_pkg
// Shared types and constants of the segment/plane crossing core.
// ----------------------------------------------------------------------------
`default_nettype none

package spx_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned THR_W           = 31;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CROSS = 3'd4;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [2:0]         hit_kind;
  } out_item_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              use_div;   // crossing with nonzero denominator
    logic [2:0]        neg;       // per axis: end below start
    logic [2:0][31:0]  base;      // final point, or start point for a division
    logic [2:0][32:0]  mag;       // per axis |end - start|
    logic [31:0]       a0;        // |d0|
    logic [32:0]       den;       // |d0| + |d1|
  } work_t;

endpackage

`default_nettype wire

### hw/rtl/spx_front.sv
// ----------------------------------------------------------------------------
// spx_front
// Plane distances of both endpoints and classification of the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [spx_pkg::THR_W-1:0]      thr,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire spx_pkg::in_item_t              in_data,
  output logic                                push_valid,
  output spx_pkg::work_t                      push_data,
  input  wire logic                           q_full
);

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic adv;

  logic signed [31:0] in_s [3];
  logic signed [31:0] in_e [3];
  logic signed [31:0] in_n [3];

  logic                  s1_vld_r;
  logic signed [63:0]    s1_ps_r [3];
  logic signed [63:0]    s1_pe_r [3];
  spx_pkg::in_item_t     s1_item_r;

  logic                  s2_vld_r;
  logic signed [31:0]    s2_d0_r;
  logic signed [31:0]    s2_d1_r;
  spx_pkg::in_item_t     s2_item_r;

  logic                  s3_vld_r;
  spx_pkg::work_t        s3_work_r;

  logic signed [49:0]    sum0;
  logic signed [49:0]    sum1;
  spx_pkg::work_t        work_nxt;

  // Stall the whole front while the last stage cannot enter the queue
  assign adv        = !s3_vld_r || !q_full;
  assign in_ready   = adv;
  assign push_valid = s3_vld_r;
  assign push_data  = s3_work_r;

  always_comb begin
    in_s[0] = in_data.start_x;  in_s[1] = in_data.start_y;  in_s[2] = in_data.start_z;
    in_e[0] = in_data.end_x;    in_e[1] = in_data.end_y;    in_e[2] = in_data.end_z;
    in_n[0] = in_data.normal_x; in_n[1] = in_data.normal_y; in_n[2] = in_data.normal_z;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1: per-axis products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_ps_r[i] <= in_n[i] * in_s[i];
        s1_pe_r[i] <= in_n[i] * in_e[i];
      end
      s1_item_r <= in_data;
    end
  end

  // Stage 2: floor to Q16.16, sum with offset, saturate
  always_comb begin
    sum0 = 50'(s1_item_r.plane_offset) + 50'(s1_ps_r[0] >>> 16)
         + 50'(s1_ps_r[1] >>> 16) + 50'(s1_ps_r[2] >>> 16);
    sum1 = 50'(s1_item_r.plane_offset) + 50'(s1_pe_r[0] >>> 16)
         + 50'(s1_pe_r[1] >>> 16) + 50'(s1_pe_r[2] >>> 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d0_r   <= sat32(sum0);
      s2_d1_r   <= sat32(sum1);
      s2_item_r <= s1_item_r;
    end
  end

  // Stage 3: classify and prepare the work item
  always_comb begin
    logic [31:0]        a0;
    logic [31:0]        a1;
    logic               same;
    logic               t0;
    logic               t1;
    logic signed [31:0] sv [3];
    logic signed [31:0] ev [3];
    logic signed [32:0] delta;
    logic signed [32:0] msum;
    logic [2:0][31:0]   mid;

    sv[0] = s2_item_r.start_x; sv[1] = s2_item_r.start_y; sv[2] = s2_item_r.start_z;
    ev[0] = s2_item_r.end_x;   ev[1] = s2_item_r.end_y;   ev[2] = s2_item_r.end_z;

    a0   = s2_d0_r[31] ? (~s2_d0_r + 32'd1) : s2_d0_r;
    a1   = s2_d1_r[31] ? (~s2_d1_r + 32'd1) : s2_d1_r;
    same = (s2_d0_r[31] && s2_d1_r[31])
        || (!s2_d0_r[31] && (s2_d0_r != 32'sd0) && !s2_d1_r[31] && (s2_d1_r != 32'sd0));
    t0   = a0 <= {1'b0, thr};
    t1   = a1 <= {1'b0, thr};

    work_nxt      = '0;
    work_nxt.a0   = a0;
    work_nxt.den  = {1'b0, a0} + {1'b0, a1};
    work_nxt.kind = same ? {1'b0, t1, t0} : spx_pkg::KIND_CROSS;
    work_nxt.use_div = !same && (work_nxt.den != 33'd0);

    for (int i = 0; i < 3; i++) begin
      delta = 33'(ev[i]) - 33'(sv[i]);
      msum  = 33'(ev[i]) + 33'(sv[i]);
      mid[i] = 32'(msum >>> 1);
      work_nxt.neg[i] = delta[32];
      work_nxt.mag[i] = delta[32] ? (~delta + 33'd1) : delta;
    end

    // Pick the point for the cases that need no division
    for (int i = 0; i < 3; i++) begin
      case (work_nxt.kind)
        spx_pkg::KIND_START: work_nxt.base[i] = sv[i];
        spx_pkg::KIND_END:   work_nxt.base[i] = ev[i];
        spx_pkg::KIND_MID:   work_nxt.base[i] = mid[i];
        spx_pkg::KIND_CROSS: work_nxt.base[i] = sv[i];
        default:             work_nxt.base[i] = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_work_r <= work_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spx_queue.sv
// ----------------------------------------------------------------------------
// spx_queue
// Small register queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_queue #(
  parameter int unsigned DEPTH = spx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  input  wire spx_pkg::work_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output spx_pkg::work_t       pop_data,
  output logic                 empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  spx_pkg::work_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push_valid && !full;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/spx_back.sv
// ----------------------------------------------------------------------------
// spx_back
// Interpolation of the crossing: one multiply stage, a pipelined restoring
// divider with one quotient bit per stage, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spx_pkg::work_t      pop_data,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spx_pkg::out_item_t       out_data
);

  // Quotient is at most |end - start|, so 33 bits
  localparam int unsigned NS = 33;

  typedef struct packed {
    logic [spx_pkg::KIND_W-1:0] kind;
    logic                       use_div;
    logic [2:0]                 neg;
    logic [2:0][31:0]           base;
    logic [32:0]                den;
  } side_t;

  logic adv;

  logic        dv_vld_r  [NS+1];
  side_t       dv_side_r [NS+1];
  logic [32:0] dv_rem_r  [NS+1][3];
  logic [32:0] dv_low_r  [NS+1][3];
  logic [32:0] dv_quo_r  [NS+1][3];

  logic [32:0] st_rem [NS][3];
  logic [32:0] st_low [NS][3];
  logic [32:0] st_quo [NS][3];

  logic [63:0] prod [3];
  side_t       side_in;

  logic                 out_valid_r;
  spx_pkg::out_item_t   out_data_r;
  spx_pkg::out_item_t   out_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && !empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Multiply stage operands
  always_comb begin
    side_in.kind    = pop_data.kind;
    side_in.use_div = pop_data.use_div;
    side_in.neg     = pop_data.neg;
    side_in.base    = pop_data.base;
    side_in.den     = pop_data.den;
    for (int i = 0; i < 3; i++) begin
      prod[i] = 64'({31'd0, pop_data.mag[i]} * {32'd0, pop_data.a0});
    end
  end

  // One restoring division step per stage
  always_comb begin
    logic [33:0] t;
    logic        ge;
    for (int k = 0; k < NS; k++) begin
      for (int i = 0; i < 3; i++) begin
        t  = {dv_rem_r[k][i], dv_low_r[k][i][32]};
        ge = t >= {1'b0, dv_side_r[k].den};
        st_rem[k][i] = ge ? 33'(t - {1'b0, dv_side_r[k].den}) : t[32:0];
        st_low[k][i] = {dv_low_r[k][i][31:0], 1'b0};
        st_quo[k][i] = {dv_quo_r[k][i][31:0], ge};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= pop;
      for (int k = 1; k <= NS; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      out_valid_r <= dv_vld_r[NS];
    end
  end

  // Advance payload through the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= side_in;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {2'b00, prod[i][63:33]};
        dv_low_r[0][i] <= prod[i][32:0];
        dv_quo_r[0][i] <= '0;
      end
      for (int k = 1; k <= NS; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k][i] <= st_rem[k-1][i];
          dv_low_r[k][i] <= st_low[k-1][i];
          dv_quo_r[k][i] <= st_quo[k-1][i];
        end
      end
      out_data_r <= out_nxt;
    end
  end

  // Apply the quotient toward the end point
  always_comb begin
    logic [33:0]  pt [3];
    logic [2:0][31:0] res;
    for (int i = 0; i < 3; i++) begin
      if (dv_side_r[NS].neg[i]) begin
        pt[i] = {{2{dv_side_r[NS].base[i][31]}}, dv_side_r[NS].base[i]}
              - {1'b0, dv_quo_r[NS][i]};
      end else begin
        pt[i] = {{2{dv_side_r[NS].base[i][31]}}, dv_side_r[NS].base[i]}
              + {1'b0, dv_quo_r[NS][i]};
      end
      res[i] = dv_side_r[NS].use_div ? pt[i][31:0] : dv_side_r[NS].base[i];
    end
    out_nxt.found    = dv_side_r[NS].kind != spx_pkg::KIND_NONE;
    out_nxt.hit_kind = dv_side_r[NS].kind;
    out_nxt.point_x  = res[0];
    out_nxt.point_y  = res[1];
    out_nxt.point_z  = res[2];
  end

endmodule

`default_nettype wire

### hw/rtl/segment_plane_crossing_core.sv
// ----------------------------------------------------------------------------
// segment_plane_crossing_core
// Crossing or touching point of a Q16.16 segment with a Q16.16 plane.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   in_data   (spx_pkg::in_item_t)
//   out_     output     out_valid/out_ready out_data  (spx_pkg::out_item_t)
//   cfg_     input      cfg_valid/cfg_ready cfg_data  (touch threshold)
//
// One beat in and one beat out per cycle when unstalled.
// The path runs through three front stages, the queue, one multiply stage,
// 33 divider stages (one quotient bit each) and the result register.
// Reset clears only control state; the threshold returns to 1.
// A stalled output freezes the back; the queue then fills and stalls the front.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_plane_crossing_core #(
  parameter int unsigned QUEUE_DEPTH = spx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire spx_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output spx_pkg::out_item_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [spx_pkg::THR_W-1:0]  cfg_data
);

  logic [spx_pkg::THR_W-1:0] thr_r;
  logic                      push_valid;
  spx_pkg::work_t            push_data;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  spx_pkg::work_t            pop_data;

  assign cfg_ready = 1'b1;

  // Hold the touch threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= spx_pkg::THR_W'(1);
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  spx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  spx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .pop_data   (pop_data),
    .empty      (q_empty)
  );

  spx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // found agrees with the kind code
  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found == (out_data.hit_kind != spx_pkg::KIND_NONE)))
    else $error("found disagrees with hit_kind");

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.hit_kind == spx_pkg::KIND_NONE) |->
      (out_data.point_x == 32'sd0) && (out_data.point_y == 32'sd0)
      && (out_data.point_z == 32'sd0))
    else $error("miss with nonzero point");

  // kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit_kind <= spx_pkg::KIND_CROSS))
    else $error("undefined hit_kind");

endmodule

`default_nettype wire

### test/tb_segment_plane_crossing_core.sv
// ----------------------------------------------------------------------------
// tb_segment_plane_crossing_core
// Self-checking bench for the segment/plane crossing core. A directed table
// covers extremes, touches, midpoints and zero denominators; random segments
// follow. Every out beat is checked against a local crossing-point model
// under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_plane_crossing_core;

  localparam int LATENCY   = 39;
  localparam int WATCH_LIM = 2000;
  localparam int N_RANDOM  = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  spx_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spx_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spx_pkg::THR_W-1:0] cfg_data = '0;

  logic [spx_pkg::THR_W-1:0] thr_model;
  spx_pkg::out_item_t crossing_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  segment_plane_crossing_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor shift by 16 of an exact product
  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint plane_dist(longint p[3], longint n[3], longint off);
    longint acc;
    acc = off;
    for (int i = 0; i < 3; i++) acc += floor16(n[i] * p[i]);
    return sat32(acc);
  endfunction

  // Expected crossing or touch point of one segment
  function automatic spx_pkg::out_item_t crossing_point(spx_pkg::in_item_t it);
    longint s[3], e[3], n[3], pt[3];
    longint d0, d1, a0, a1, delta;
    logic [63:0] q, den;
    logic [2:0] flag;
    spx_pkg::out_item_t r;
    s = '{it.start_x, it.start_y, it.start_z};
    e = '{it.end_x, it.end_y, it.end_z};
    n = '{it.normal_x, it.normal_y, it.normal_z};
    pt = '{0, 0, 0};
    d0 = plane_dist(s, n, it.plane_offset);
    d1 = plane_dist(e, n, it.plane_offset);
    a0 = d0 < 0 ? -d0 : d0;
    a1 = d1 < 0 ? -d1 : d1;
    r = '0;
    if ((d0 > 0 && d1 > 0) || (d0 < 0 && d1 < 0)) begin
      flag = '0;
      if (a0 <= longint'(thr_model)) flag[0] = 1'b1;
      if (a1 <= longint'(thr_model)) flag[1] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (flag == spx_pkg::KIND_START) pt[i] = s[i];
        else if (flag == spx_pkg::KIND_END) pt[i] = e[i];
        else if (flag == spx_pkg::KIND_MID) pt[i] = (s[i] + e[i]) >>> 1;
      end
      r.hit_kind = flag;
      r.found = flag != spx_pkg::KIND_NONE;
    end else begin
      den = a0 + a1;
      r.hit_kind = spx_pkg::KIND_CROSS;
      r.found = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (den == 0) begin
          pt[i] = s[i];
        end else begin
          delta = e[i] - s[i];
          q = ((delta < 0 ? -delta : delta) * a0) / den;
          pt[i] = delta < 0 ? s[i] - longint'(q) : s[i] + longint'(q);
        end
      end
    end
    r.point_x = pt[0][31:0];
    r.point_y = pt[1][31:0];
    r.point_z = pt[2][31:0];
    return r;
  endfunction

  function automatic spx_pkg::in_item_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                           int nx, int ny, int nz, int off);
    spx_pkg::in_item_t it;
    it = '{sx, sy, sz, ex, ey, ez, nx, ny, nz, off};
    return it;
  endfunction

  // Push one segment through the input channel; valid stays up for the next one
  task automatic send_segment(spx_pkg::in_item_t it, bit noidle);
    int gap;
    gap = noidle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    crossing_q.push_back(crossing_point(it));
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (crossing_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [spx_pkg::THR_W-1:0] v);
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_model = v;
    cfg_valid <= 1'b0;
  endtask

  // Random segment: mostly small coordinates, sometimes full range
  function automatic int rcoord(bit wide);
    return wide ? int'($urandom) : $signed($urandom_range(0, 32'h00100000)) - 32'h80000;
  endfunction

  function automatic spx_pkg::in_item_t rand_segment();
    spx_pkg::in_item_t it;
    bit wide;
    wide = $urandom_range(0, 9) == 0;
    it.start_x = rcoord(wide); it.start_y = rcoord(wide); it.start_z = rcoord(wide);
    it.end_x = rcoord(wide); it.end_y = rcoord(wide); it.end_z = rcoord(wide);
    it.normal_x = rcoord(wide); it.normal_y = rcoord(wide); it.normal_z = rcoord(wide);
    it.plane_offset = rcoord(wide);
    // Keep the plane near the segment so crossings and touches are common
    if (!wide && $urandom_range(0, 1)) it.plane_offset = $signed($urandom_range(0, 255)) - 128;
    if ($urandom_range(0, 7) == 0) begin
      it.normal_x = 0; it.normal_y = 0; it.normal_z = 0;
    end
    return it;
  endfunction

  // Output side: compare each beat with the oldest expectation
  always @(posedge clk) begin
    spx_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (crossing_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = crossing_q.pop_front();
        if (out_data.found !== exp_r.found) begin
          $display("%0t: found exp %0d got %0d", $time, exp_r.found, out_data.found);
          errors++;
        end
        if (out_data.point_x !== exp_r.point_x) begin
          $display("%0t: point_x exp %h got %h", $time, exp_r.point_x, out_data.point_x);
          errors++;
        end
        if (out_data.point_y !== exp_r.point_y) begin
          $display("%0t: point_y exp %h got %h", $time, exp_r.point_y, out_data.point_y);
          errors++;
        end
        if (out_data.point_z !== exp_r.point_z) begin
          $display("%0t: point_z exp %h got %h", $time, exp_r.point_z, out_data.point_z);
          errors++;
        end
        if (out_data.hit_kind !== exp_r.hit_kind) begin
          $display("%0t: hit_kind exp %0d got %0d", $time, exp_r.hit_kind,
                   out_data.hit_kind);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: drop ready at random between accepted beats
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = stim_done ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Watchdog on cycles with no beat accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIM) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed table
  typedef struct {
    spx_pkg::in_item_t   stim;
    bit                  typed;
    spx_pkg::out_item_t  result;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(spx_pkg::in_item_t it, bit typed, spx_pkg::out_item_t r);
    dir_row_t row;
    row.stim = it; row.typed = typed; row.result = r;
    dir_rows.push_back(row);
  endtask

  localparam int ONE = 32'h10000;
  localparam int MAXV = 32'h7fffffff;
  localparam int MINV = 32'h80000000;

  initial begin
    spx_pkg::out_item_t r;
    thr_model = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Zero normal and offset: both distances zero, start point returned
    add_row(mk(ONE, 2*ONE, 3*ONE, 5, 6, 7, 0, 0, 0, 0), 1,
            '{1'b1, ONE, 2*ONE, 3*ONE, spx_pkg::KIND_CROSS});
    // Same side far away: no hit
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE), 1,
            '{1'b0, 0, 0, 0, spx_pkg::KIND_NONE});
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, -ONE), 1,
            '{1'b0, 0, 0, 0, spx_pkg::KIND_NONE});
    // Both endpoints one ulp off the plane: midpoint
    add_row(mk(-3, 4, 0, 6, -9, 0, 0, 0, 0, 1), 1, '{1'b1, 1, -3, 0, spx_pkg::KIND_MID});
    // Start touches, end touches
    add_row(mk(0, 0, 0, 10*ONE, 0, 0, ONE, 0, 0, 1), 0, r);
    add_row(mk(10*ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 1), 0, r);
    // Ordinary crossings on each axis
    add_row(mk(-ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, 0), 0, r);
    add_row(mk(0, -ONE, 3, 0, 3*ONE, 3, 0, ONE, 0, 0), 0, r);
    add_row(mk(5, 5, 2*ONE, 5, 5, -ONE, 0, 0, -ONE, ONE/2), 0, r);
    // Extremes and saturated distances
    add_row(mk(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV), 0, r);
    add_row(mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV), 0, r);
    add_row(mk(MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0), 0, r);
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0, r);
    add_row(mk(MINV, 0, 0, MINV, 0, 0, MINV, 0, 0, MINV), 0, r);
    add_row(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, r);

    foreach (dir_rows[i]) begin
      send_segment(dir_rows[i].stim, 1'b0);
      if (dir_rows[i].typed && crossing_q[$] != dir_rows[i].result) begin
        $display("%0t: table row %0d exp %h model %h", $time, i,
                 dir_rows[i].result, crossing_q[$]);
        errors++;
      end
    end

    // Threshold sweep: zero, max, 0x4000, then random
    write_threshold('0);
    for (int i = 0; i < 6; i++) send_segment(dir_rows[i].stim, 1'b0);
    write_threshold(31'h7fffffff);
    for (int i = 0; i < 6; i++) send_segment(dir_rows[i].stim, 1'b0);
    write_threshold(31'h00004000);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) drain_results();
      if (k == N_RANDOM / 2) write_threshold(31'($urandom_range(0, 31'h7fffffff)));
      if (k == (2 * N_RANDOM) / 3) write_threshold(31'($urandom_range(0, 31'h00100000)));
      send_segment(rand_segment(), (k % 100) > 80);
    end

    stim_done = 1'b1;
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && crossing_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire
